>>> rtl/jms_pkg.sv
// ----------------------------------------------------------------------------
// jms_pkg
// Shared types, constants and the marker classifier for the JPEG marker
// scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jms_pkg;

  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned MAX_TABLES  = 4;

  localparam int unsigned OUT_OFF_W = 24;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned LEN_W     = 16;

  localparam logic [7:0] BYTE_FF     = 8'hFF;
  localparam logic [7:0] BYTE_ESC    = 8'h00;
  localparam logic [7:0] BYTE_SOI    = 8'hD8;
  localparam logic [7:0] BYTE_EOI    = 8'hD9;
  localparam logic [7:0] BYTE_DQT    = 8'hDB;
  localparam logic [7:0] BYTE_DHT    = 8'hC4;
  localparam logic [7:0] BYTE_DRI    = 8'hDD;
  localparam logic [7:0] BYTE_SOF    = 8'hC0;
  localparam logic [7:0] BYTE_SOS    = 8'hDA;
  localparam logic [7:0] BYTE_APP_LO = 8'hE0;
  localparam logic [7:0] BYTE_APP_HI = 8'hEF;
  localparam logic [7:0] SAMP_H1V2   = 8'h21;
  localparam logic [7:0] SAMP_H2V2   = 8'h22;

  localparam logic [1:0] MODE_H1V2 = 2'd0;
  localparam logic [1:0] MODE_H2V2 = 2'd2;

  localparam logic [LEN_W-1:0] SOF_SAMP_INDEX = 16'd9;
  localparam logic [LEN_W-1:0] MIN_SEG_LEN    = 16'd2;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_SOI     = 4'd1,
    EV_APP     = 4'd2,
    EV_DQT     = 4'd3,
    EV_DHT     = 4'd4,
    EV_DRI     = 4'd5,
    EV_SOF     = 4'd6,
    EV_SOS     = 4'd7,
    EV_EOI     = 4'd8,
    EV_UNKNOWN = 4'd9,
    EV_ESCAPE  = 4'd10
  } event_e;

  typedef enum logic [5:0] {
    PH_SCAN   = 6'b000001,
    PH_MARKER = 6'b000010,
    PH_LEN_HI = 6'b000100,
    PH_LEN_LO = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  function automatic event_e classify(input logic [7:0] b);
    event_e k;
    k = EV_UNKNOWN;
    if (b == BYTE_ESC) k = EV_ESCAPE;
    else if (b == BYTE_SOI) k = EV_SOI;
    else if (b == BYTE_EOI) k = EV_EOI;
    else if (b == BYTE_DQT) k = EV_DQT;
    else if (b == BYTE_DHT) k = EV_DHT;
    else if (b == BYTE_DRI) k = EV_DRI;
    else if (b == BYTE_SOF) k = EV_SOF;
    else if (b == BYTE_SOS) k = EV_SOS;
    else if (b >= BYTE_APP_LO && b <= BYTE_APP_HI) k = EV_APP;
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/jpeg_marker_scanner.sv
// a result is registered and valid the cycle after its byte is accepted
// throughput: one byte per cycle while out_ready_i holds, limited by the single result register
// a new byte is taken while the current result is being taken
// status outputs come straight from the scan state registers
// reset (rst_ni low, asynchronous) clears all scan state; restart_i clears
// it for the byte it comes with
// ----------------------------------------------------------------------------
// jpeg_marker_scanner
// Scans a JPEG byte stream one byte per transaction, classifies markers,
// skips segments and tracks table, sampling and image data offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_marker_scanner (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [7:0]                     byte_value_i,
  input  wire logic                           restart_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [3:0]                     event_res_o,
  output      logic [jms_pkg::OUT_OFF_W-1:0]  table_offset_o,
  output      logic [jms_pkg::CNT_W-1:0]      dqt_count_o,
  output      logic [jms_pkg::CNT_W-1:0]      dht_count_o,
  output      logic [1:0]                     mode_o,
  output      logic [jms_pkg::OUT_OFF_W-1:0]  image_offset_o,
  output      logic                           image_found_o,
  output      logic                           done_res_o,
  output      logic                           overflow_o
);
  import jms_pkg::*;

  localparam int unsigned OFF_W = OFFSET_BITS;

  phase_e               phase_q, phase_d, ph_c;
  event_e               kind_q, kind_d, kind_c;
  logic [7:0]           len_hi_q, len_hi_d, len_hi_c;
  logic [LEN_W-1:0]     left_q, left_d, left_c;
  logic [LEN_W-1:0]     index_q, index_d, index_c;
  logic [OFF_W-1:0]     start_q, start_d, start_c;
  logic [OFF_W-1:0]     pos_q, pos_d, pos_c;
  logic [CNT_W-1:0]     dqt_q, dqt_d, dqt_c;
  logic [CNT_W-1:0]     dht_q, dht_d, dht_c;
  logic [1:0]           mode_q, mode_d, mode_c;
  logic [OFF_W-1:0]     data_q, data_d, data_c;
  logic                 found_q, found_d, found_c;
  logic                 fin_q, fin_d, fin_c;
  logic                 ovf_q, ovf_d, ovf_c;

  event_e               ev_q, ev_d;
  logic [OFF_W-1:0]     toff_q, toff_d;
  logic                 out_valid_q, out_valid_d;

  logic                 accept;
  event_e               cls;
  logic [LEN_W-1:0]     seg_len;
  logic [LEN_W-1:0]     left_dec;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign cls        = classify(byte_value_i);

  always_comb begin
    // state as seen by this byte, cleared on restart
    ph_c     = restart_i ? PH_SCAN : phase_q;
    kind_c   = restart_i ? EV_NONE : kind_q;
    len_hi_c = restart_i ? '0 : len_hi_q;
    left_c   = restart_i ? '0 : left_q;
    index_c  = restart_i ? '0 : index_q;
    start_c  = restart_i ? '0 : start_q;
    pos_c    = restart_i ? '0 : pos_q;
    dqt_c    = restart_i ? '0 : dqt_q;
    dht_c    = restart_i ? '0 : dht_q;
    mode_c   = restart_i ? '0 : mode_q;
    data_c   = restart_i ? '0 : data_q;
    found_c  = restart_i ? 1'b0 : found_q;
    fin_c    = restart_i ? 1'b0 : fin_q;
    ovf_c    = restart_i ? 1'b0 : ovf_q;

    phase_d  = ph_c;
    kind_d   = kind_c;
    len_hi_d = len_hi_c;
    left_d   = left_c;
    index_d  = index_c;
    start_d  = start_c;
    pos_d    = pos_c;
    dqt_d    = dqt_c;
    dht_d    = dht_c;
    mode_d   = mode_c;
    data_d   = data_c;
    found_d  = found_c;
    fin_d    = fin_c;
    ovf_d    = ovf_c;
    ev_d     = EV_NONE;
    toff_d   = '0;

    seg_len  = {len_hi_c, byte_value_i};
    if (seg_len < MIN_SEG_LEN) seg_len = MIN_SEG_LEN;
    left_dec = left_c - 1'b1;

    if (!fin_c) begin
      case (ph_c)
        PH_SCAN: begin
          if (byte_value_i == BYTE_FF) phase_d = PH_MARKER;
        end
        PH_MARKER: begin
          if (cls == EV_ESCAPE || cls == EV_SOI) begin
            ev_d    = cls;
            phase_d = PH_SCAN;
          end else if (cls == EV_EOI) begin
            ev_d    = cls;
            fin_d   = 1'b1;
            phase_d = PH_DONE;
          end else begin
            kind_d  = cls;
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          start_d  = pos_c;
          len_hi_d = byte_value_i;
          index_d  = LEN_W'(1);
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          index_d = LEN_W'(2);
          left_d  = seg_len - MIN_SEG_LEN;
          ev_d    = kind_c;
          if (kind_c == EV_DQT) begin
            toff_d = start_c + OFF_W'(2);
            if ({1'b0, dqt_c} >= (CNT_W+1)'(MAX_TABLES)) ovf_d = 1'b1;
            else dqt_d = dqt_c + 1'b1;
          end else if (kind_c == EV_DHT) begin
            toff_d = start_c + OFF_W'(2);
            if ({1'b0, dht_c} >= (CNT_W+1)'(MAX_TABLES)) ovf_d = 1'b1;
            else dht_d = dht_c + 1'b1;
          end else if (kind_c == EV_SOS) begin
            data_d  = start_c + OFF_W'(seg_len);
            found_d = 1'b1;
          end
          phase_d = (seg_len == MIN_SEG_LEN) ? PH_SCAN : PH_SKIP;
        end
        PH_SKIP: begin
          if (kind_c == EV_SOF && index_c == SOF_SAMP_INDEX) begin
            if (byte_value_i == SAMP_H1V2) mode_d = MODE_H1V2;
            else if (byte_value_i == SAMP_H2V2) mode_d = MODE_H2V2;
          end
          index_d = index_c + 1'b1;
          left_d  = left_dec;
          if (left_dec == '0) phase_d = PH_SCAN;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
      pos_d = pos_c + 1'b1;
    end

    out_valid_d = accept ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SCAN;
      kind_q      <= EV_NONE;
      len_hi_q    <= '0;
      left_q      <= '0;
      index_q     <= '0;
      start_q     <= '0;
      pos_q       <= '0;
      dqt_q       <= '0;
      dht_q       <= '0;
      mode_q      <= '0;
      data_q      <= '0;
      found_q     <= 1'b0;
      fin_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q  <= phase_d;
        kind_q   <= kind_d;
        len_hi_q <= len_hi_d;
        left_q   <= left_d;
        index_q  <= index_d;
        start_q  <= start_d;
        pos_q    <= pos_d;
        dqt_q    <= dqt_d;
        dht_q    <= dht_d;
        mode_q   <= mode_d;
        data_q   <= data_d;
        found_q  <= found_d;
        fin_q    <= fin_d;
        ovf_q    <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q   <= ev_d;
      toff_q <= toff_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = ev_q;
  assign table_offset_o = OUT_OFF_W'(toff_q);
  assign dqt_count_o    = dqt_q;
  assign dht_count_o    = dht_q;
  assign mode_o         = mode_q;
  assign image_offset_o = OUT_OFF_W'(data_q);
  assign image_found_o  = found_q;
  assign done_res_o     = fin_q;
  assign overflow_o     = ovf_q;

`ifndef SYNTHESIS
  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q == (phase_q == PH_DONE))
    else $error("done flag and done phase disagree");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted byte produced no result");

  a_ovf_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(accept && !restart_i))
    else $error("overflow set without a transaction");

  a_found_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(found_q) |-> $past(accept && restart_i))
    else $error("image_found cleared without restart");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the JPEG marker scanner a short hand-built stream, then randomly built
// files: well-formed segments, table bursts, truncated segments, stray bytes,
// noise and restarts. A scoreboard tracks the scan state per transaction and
// compares every result field by field while both sides idle at random, except in a steady stretch.
// ----------------------------------------------------------------------------
module testbench;
  import jms_pkg::*;

  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned TARGET_ITEMS = 1350;
  localparam int unsigned IDLE_PCT     = 25;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [3:0]           kind;
    logic [OUT_OFF_W-1:0] table_offset;
    logic [CNT_W-1:0]     dqt_count;
    logic [CNT_W-1:0]     dht_count;
    logic [1:0]           mode;
    logic [OUT_OFF_W-1:0] image_offset;
    logic                 image_found;
    logic                 finished;
    logic                 overflow;
  } scan_report_t;

  typedef struct packed {
    logic [7:0] value;
    logic       restart;
  } scan_byte_t;

  class marker_scoreboard;
    scan_report_t expected_reports[$];
    int unsigned  mismatches;
    int unsigned  reports_compared;
    int unsigned  kind_hits[16];
    bit           overflow_seen;

    phase_e                 phase;
    event_e                 seg_kind;
    logic [LEN_W-1:0]       seg_len;
    logic [LEN_W-1:0]       bytes_left;
    logic [LEN_W-1:0]       seg_index;
    logic [OFFSET_BITS-1:0] seg_start;
    logic [OFFSET_BITS-1:0] byte_pos;
    logic [OFFSET_BITS-1:0] data_start;
    logic [CNT_W-1:0]       quant_seen;
    logic [CNT_W-1:0]       huff_seen;
    logic [1:0]             samp_mode;
    logic                   data_found;
    logic                   finished;
    logic                   table_overflow;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      phase          = PH_SCAN;
      seg_kind       = EV_NONE;
      seg_len        = '0;
      bytes_left     = '0;
      seg_index      = '0;
      seg_start      = '0;
      byte_pos       = '0;
      data_start     = '0;
      quant_seen     = '0;
      huff_seen      = '0;
      samp_mode      = '0;
      data_found     = 1'b0;
      finished       = 1'b0;
      table_overflow = 1'b0;
    endfunction

    function event_e kind_of(input logic [7:0] b);
      case (b)
        BYTE_ESC: return EV_ESCAPE;
        BYTE_SOI: return EV_SOI;
        BYTE_EOI: return EV_EOI;
        BYTE_DQT: return EV_DQT;
        BYTE_DHT: return EV_DHT;
        BYTE_DRI: return EV_DRI;
        BYTE_SOF: return EV_SOF;
        BYTE_SOS: return EV_SOS;
        default:  return (b >= BYTE_APP_LO && b <= BYTE_APP_HI) ? EV_APP : EV_UNKNOWN;
      endcase
    endfunction

    function void note_byte(input logic [7:0] b, input logic restart);
      scan_report_t           want;
      event_e                 ev;
      event_e                 k;
      logic [OFFSET_BITS-1:0] toff;
      if (restart) clear_state();
      ev   = EV_NONE;
      toff = '0;
      if (!finished) begin
        case (phase)
          PH_SCAN: begin
            if (b == BYTE_FF) phase = PH_MARKER;
          end
          PH_MARKER: begin
            k = kind_of(b);
            if (k == EV_ESCAPE || k == EV_SOI) begin
              ev    = k;
              phase = PH_SCAN;
            end else if (k == EV_EOI) begin
              ev       = k;
              finished = 1'b1;
              phase    = PH_DONE;
            end else begin
              seg_kind = k;
              phase    = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            seg_start = byte_pos;
            seg_len   = {b, 8'h00};
            seg_index = 16'd1;
            phase     = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            seg_len = seg_len | {8'h00, b};
            if (seg_len < MIN_SEG_LEN) seg_len = MIN_SEG_LEN;
            seg_index  = 16'd2;
            bytes_left = seg_len - MIN_SEG_LEN;
            ev         = seg_kind;
            if (seg_kind == EV_DQT) begin
              toff = seg_start + OFFSET_BITS'(2);
              if (quant_seen >= MAX_TABLES) table_overflow = 1'b1;
              else quant_seen++;
            end else if (seg_kind == EV_DHT) begin
              toff = seg_start + OFFSET_BITS'(2);
              if (huff_seen >= MAX_TABLES) table_overflow = 1'b1;
              else huff_seen++;
            end else if (seg_kind == EV_SOS) begin
              data_start = seg_start + OFFSET_BITS'(seg_len);
              data_found = 1'b1;
            end
            phase = (bytes_left == 0) ? PH_SCAN : PH_SKIP;
          end
          PH_SKIP: begin
            if (seg_kind == EV_SOF && seg_index == SOF_SAMP_INDEX) begin
              if (b == SAMP_H1V2) samp_mode = MODE_H1V2;
              else if (b == SAMP_H2V2) samp_mode = MODE_H2V2;
            end
            seg_index++;
            bytes_left--;
            if (bytes_left == 0) phase = PH_SCAN;
          end
          default: begin
            phase = PH_DONE;
          end
        endcase
        byte_pos++;
      end
      if (table_overflow) overflow_seen = 1'b1;
      kind_hits[ev]++;
      want.kind         = ev;
      want.table_offset = toff;
      want.dqt_count    = quant_seen;
      want.dht_count    = huff_seen;
      want.mode         = samp_mode;
      want.image_offset = data_start;
      want.image_found  = data_found;
      want.finished     = finished;
      want.overflow     = table_overflow;
      expected_reports.push_back(want);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input scan_report_t got);
      scan_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result transaction with nothing expected, event_res %0d", got.kind);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      reports_compared++;
      compare_field("event_res", want.kind, got.kind);
      compare_field("table_offset", want.table_offset, got.table_offset);
      compare_field("dqt_count", want.dqt_count, got.dqt_count);
      compare_field("dht_count", want.dht_count, got.dht_count);
      compare_field("mode", want.mode, got.mode);
      compare_field("image_offset", want.image_offset, got.image_offset);
      compare_field("image_found", want.image_found, got.image_found);
      compare_field("done_res", want.finished, got.finished);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           byte_value_i = 8'h00;
  logic                 restart_i    = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [3:0]           event_res_o;
  logic [OUT_OFF_W-1:0] table_offset_o;
  logic [CNT_W-1:0]     dqt_count_o;
  logic [CNT_W-1:0]     dht_count_o;
  logic [1:0]           mode_o;
  logic [OUT_OFF_W-1:0] image_offset_o;
  logic                 image_found_o;
  logic                 done_res_o;
  logic                 overflow_o;

  marker_scoreboard sb;
  scan_byte_t       byte_stream[$];
  int unsigned      stimulus_items = 0;
  int unsigned      streams_built  = 0;
  int unsigned      bytes_sent     = 0;
  int unsigned      cycle_count    = 0;
  bit               steady_stretch = 1'b0;

  jpeg_marker_scanner DUT (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timed out after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({event_res_o, table_offset_o, dqt_count_o, dht_count_o, mode_o,
                       image_offset_o, image_found_o, done_res_o, overflow_o});
    end
  end

  function automatic void push_byte(input logic [7:0] value, input logic restart = 1'b0);
    byte_stream.push_back({value, restart});
    stimulus_items++;
  endfunction

  // body byte 7 is segment byte 9, the Y sampling byte of an SOF
  function automatic void push_segment(input logic [7:0] marker, input logic [15:0] len_field,
                                       input int unsigned body, input logic [7:0] samp);
    push_byte(BYTE_FF);
    push_byte(marker);
    push_byte(len_field[15:8]);
    push_byte(len_field[7:0]);
    for (int unsigned i = 0; i < body; i++) begin
      push_byte((marker == BYTE_SOF && i == 7) ? samp : 8'($urandom_range(255)));
    end
  endfunction

  function automatic logic [7:0] length_marker();
    case ($urandom_range(5))
      0:       return 8'(BYTE_APP_LO + $urandom_range(15));
      1:       return BYTE_DQT;
      2:       return BYTE_DHT;
      3:       return BYTE_DRI;
      4:       return BYTE_SOF;
      default: return BYTE_SOS;
    endcase
  endfunction

  function automatic void build_random_file();
    int unsigned body;
    logic [7:0]  m;
    logic [7:0]  samp;
    streams_built++;
    // pure noise
    if ($urandom_range(99) < 8) begin
      push_byte(8'($urandom_range(255)), 1'b1);
      repeat ($urandom_range(40, 5)) push_byte(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(99) < 90) begin
      push_byte(BYTE_FF, 1'b1);
      push_byte(BYTE_SOI);
    end else begin
      push_byte(8'($urandom_range(254)), 1'b1);
    end
    // table burst, can run the counts into saturation
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(7, 3)) begin
        body = $urandom_range(6);
        push_segment(($urandom_range(1) != 0) ? BYTE_DQT : BYTE_DHT, 16'(body + 2), body, 8'h00);
      end
    end
    repeat ($urandom_range(10, 2)) begin
      body = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
      case ($urandom_range(11))
        0: push_segment(8'(BYTE_APP_LO + $urandom_range(15)), 16'(body + 2), body, 8'h00);
        1, 2: push_segment(BYTE_DQT, 16'(body + 2), body, 8'h00);
        3, 4: push_segment(BYTE_DHT, 16'(body + 2), body, 8'h00);
        5: push_segment(BYTE_DRI, 16'(body + 2), body, 8'h00);
        6: begin
          body = $urandom_range(14, 5);
          if ($urandom_range(4) < 2) samp = SAMP_H1V2;
          else if ($urandom_range(2) != 0) samp = SAMP_H2V2;
          else samp = 8'($urandom_range(255));
          push_segment(BYTE_SOF, 16'(body + 2), body, samp);
        end
        7: begin
          push_segment(BYTE_SOS, 16'(body + 2), body, 8'h00);
          repeat ($urandom_range(20)) begin
            if ($urandom_range(9) == 0) begin
              push_byte(BYTE_FF);
              push_byte(BYTE_ESC);
            end else begin
              push_byte(8'($urandom_range(254)));
            end
          end
        end
        8: begin
          // unknown markers, fill bytes and restart markers among them
          do m = 8'($urandom_range(255)); while (sb.kind_of(m) != EV_UNKNOWN);
          push_segment(m, 16'(body + 2), body, 8'h00);
        end
        9: push_segment(length_marker(), 16'($urandom_range(1)), 0, 8'h00);
        10: begin
          repeat ($urandom_range(4)) push_byte(8'($urandom_range(254)));
          push_byte(BYTE_FF);
          push_byte(BYTE_ESC);
        end
        default: begin
          // length longer than the bytes that follow
          push_segment(length_marker(), 16'(body + 2 + $urandom_range(30, 1)), body,
                       SAMP_H2V2);
        end
      endcase
    end
    if ($urandom_range(99) < 85) begin
      push_byte(BYTE_FF);
      push_byte(BYTE_EOI);
      repeat ($urandom_range(3)) byte_stream.push_back({8'($urandom_range(255)), 1'b0});
    end
  endfunction

  task automatic send_byte(input scan_byte_t item);
    while (!steady_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= item.value;
    restart_i    <= item.restart;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(item.value, item.restart);
    bytes_sent++;
    steady_stretch = (bytes_sent >= 600 && bytes_sent < 900);
  endtask

  task automatic drive_stream();
    while (byte_stream.size() != 0) send_byte(byte_stream.pop_front());
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned kinds_seen;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_byte(BYTE_FF, 1'b1);
    push_byte(BYTE_SOI);
    push_byte(BYTE_FF);
    push_byte(BYTE_ESC);
    // fill byte taken as a marker, with a length below the minimum
    push_segment(BYTE_FF, 16'd1, 0, 8'h00);
    push_segment(BYTE_DQT, 16'd2, 0, 8'h00);
    push_segment(BYTE_DHT, 16'd0, 0, 8'h00);
    push_segment(BYTE_DRI, 16'd2, 0, 8'h00);
    // sof too short to hold the sampling byte
    push_segment(BYTE_SOF, 16'd2, 0, 8'h00);
    push_segment(BYTE_SOS, 16'd2, 0, 8'h00);
    push_byte(BYTE_FF);
    push_byte(BYTE_EOI);
    push_byte(BYTE_FF);
    drive_stream();
    while (sb.expected_reports.size() != 0) @(posedge clk_i);

    while (stimulus_items < TARGET_ITEMS) build_random_file();
    drive_stream();
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    kinds_seen = 0;
    for (int k = EV_SOI; k <= EV_ESCAPE; k++) begin
      if (sb.kind_hits[k] != 0) kinds_seen++;
    end
    $display("scanned %0d bytes over %0d streams, %0d results compared",
             bytes_sent, streams_built, sb.reports_compared);
    $display("%0d of 10 marker event kinds reported, table overflow reached: %0d",
             kinds_seen, sb.overflow_seen);
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/jms_pkg.sv
rtl/jpeg_marker_scanner.sv
test/testbench.sv
